// ----- rtl/core/tidx_pkg.sv -----
// Shared types, constants and helpers for the tagged index table.
package tidx_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  localparam int MODE_W   = 3;
  localparam int GKEY_W   = 16;
  localparam int SLOT_W   = 4;
  localparam int SIZE_W   = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  // Marker for "no slot": slot_out reads as this on any failure.
  localparam logic [SLOT_W-1:0] NO_SLOT    = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIND_FREE = 3'd0,
    MODE_LOOKUP    = 3'd1,
    MODE_SET_SLOT  = 3'd2,
    MODE_FREE_SLOT = 3'd3,
    MODE_FREE_KEY  = 3'd4,
    MODE_READ_SLOT = 3'd5
  } tidx_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RDWAIT,
    ST_RESP
  } tidx_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [GKEY_W-1:0] global_key;
    logic [SLOT_W-1:0] slot_number;
  } tidx_req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [GKEY_W-1:0] key_out;
  } tidx_rsp_t;

  // Command from the sequencer to the slot store.
  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                wr_valid;
    logic [KEY_BITS-1:0] wr_key;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
  } tidx_cmd_t;

  function automatic logic [KEY_BITS-1:0] key_to_store(input logic [GKEY_W-1:0] k);
    logic [31:0] ext;
    ext = 32'(k);
    return ext[KEY_BITS-1:0];
  endfunction

  function automatic logic [GKEY_W-1:0] key_to_port(input logic [KEY_BITS-1:0] k);
    logic [31:0] ext;
    ext = 32'(k);
    return ext[GKEY_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] idx_to_port(input logic [IDX_W-1:0] i);
    logic [31:0] ext;
    ext = 32'(i);
    return ext[SLOT_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] s);
    logic [31:0] ext;
    ext = 32'(s);
    return ext[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tidx_store.sv -----
// Slot store: per-slot valid flags in flops and a key memory with registered read.
module tidx_store import tidx_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  tidx_cmd_t           cmd,
  output logic                rd_valid,
  output logic [KEY_BITS-1:0] rd_key
);

  logic [ENTRIES-1:0]  valid_r;
  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic                rd_valid_r;
  logic [KEY_BITS-1:0] rd_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[cmd.wr_addr] <= cmd.wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_mem[cmd.wr_addr] <= cmd.wr_key;
    end
  end

  // Never-written entries are masked by their clear valid flag.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_valid_r <= valid_r[cmd.rd_addr];
      rd_key_r   <= key_mem[cmd.rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_key   = rd_valid_r ? rd_key_r : '0;

endmodule

// ----- rtl/core/tidx_seq.sv -----
// Request sequencer: decodes a request and steps the slot compare over the store.
module tidx_seq import tidx_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  tidx_req_t           req,
  input  logic [CNT_W-1:0]    eff_size,
  output tidx_cmd_t           cmd,
  input  logic                rd_valid,
  input  logic [KEY_BITS-1:0] rd_key,
  output logic                rsp_valid,
  output tidx_rsp_t           rsp,
  input  logic                rsp_take
);

  tidx_state_t         state_r, state_nxt;
  tidx_req_t           req_r, req_nxt;
  tidx_rsp_t           rsp_r, rsp_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                chk_r, chk_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;

  logic                slot_ok;
  logic                issue;
  logic                match;
  logic [KEY_BITS-1:0] req_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    rsp_r     <= rsp_nxt;
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
  end

  assign req_key = key_to_store(req_r.global_key);
  assign slot_ok = (32'(req_r.slot_number) < 32'(eff_size));
  assign issue   = (idx_r < eff_size);

  // Shared slot compare: free slot for find, matching active key otherwise.
  always_comb begin
    if (tidx_mode_t'(req_r.mode) == MODE_FIND_FREE) begin
      match = chk_r && !rd_valid;
    end else begin
      match = chk_r && rd_valid && (rd_key == req_key);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    rsp_nxt     = rsp_r;
    idx_nxt     = idx_r;
    chk_nxt     = chk_r;
    chk_idx_nxt = chk_idx_r;
    cmd         = '0;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt   = req;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        rsp_nxt          = '0;
        rsp_nxt.slot_out = NO_SLOT;
        state_nxt        = ST_RESP;
        case (tidx_mode_t'(req_r.mode))
          MODE_FIND_FREE, MODE_LOOKUP, MODE_FREE_KEY: begin
            idx_nxt   = '0;
            chk_nxt   = 1'b0;
            state_nxt = ST_SCAN;
          end
          MODE_SET_SLOT: begin
            if (slot_ok) begin
              cmd.wr_en    = 1'b1;
              cmd.wr_addr  = slot_to_idx(req_r.slot_number);
              cmd.wr_valid = 1'b1;
              cmd.wr_key   = req_key;
              rsp_nxt.ok   = 1'b1;
            end
          end
          MODE_FREE_SLOT: begin
            if (slot_ok) begin
              cmd.wr_en    = 1'b1;
              cmd.wr_addr  = slot_to_idx(req_r.slot_number);
              rsp_nxt.ok   = 1'b1;
            end
          end
          MODE_READ_SLOT: begin
            if (slot_ok) begin
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = slot_to_idx(req_r.slot_number);
              state_nxt   = ST_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        if (match) begin
          rsp_nxt.ok       = 1'b1;
          rsp_nxt.slot_out = idx_to_port(chk_idx_r);
          if (tidx_mode_t'(req_r.mode) == MODE_FREE_KEY) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = chk_idx_r;
          end
          chk_nxt   = 1'b0;
          state_nxt = ST_RESP;
        end else if (issue) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
          chk_nxt     = 1'b1;
          chk_idx_nxt = idx_r[IDX_W-1:0];
        end else begin
          chk_nxt = 1'b0;
          if (!chk_r) begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_RDWAIT: begin
        rsp_nxt.ok      = 1'b1;
        rsp_nxt.key_out = key_to_port(rd_key);
        state_nxt       = ST_RESP;
      end

      ST_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rsp = rsp_r;

endmodule

// ----- rtl/core/tagged_index_table_top.sv -----
// Top level of the tagged index table: config register, sequencer, store, output register.
// One transaction at a time in the sequencer: a scan steps through the single compare
// unit and the one store read port, and a new request is taken only after the previous
// result has moved into the output register.
// Reset: synchronous active-low rst_n clears valid flags, sequencer state and output valid, size is 16.
module tagged_index_table_top import tidx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tidx_req_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tidx_rsp_t         out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  logic [SIZE_W-1:0]   table_size_r;
  logic [CNT_W-1:0]    eff_size;
  tidx_cmd_t           cmd;
  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  logic                rsp_valid;
  tidx_rsp_t           rsp;
  logic                rsp_take;
  logic                out_valid_r;
  tidx_rsp_t           out_data_r;

  // Hold the table size; write it only while no transaction is in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // Saturate the configured size to the physical slot count.
  always_comb begin
    if (32'(table_size_r) > ENTRIES) begin
      eff_size = CNT_W'(ENTRIES);
    end else begin
      eff_size = CNT_W'(table_size_r);
    end
  end

  tidx_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (in_data),
    .eff_size  (eff_size),
    .cmd       (cmd),
    .rd_valid  (rd_valid),
    .rd_key    (rd_key),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_take  (rsp_take)
  );

  tidx_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_valid (rd_valid),
    .rd_key   (rd_key)
  );

  // Output register: take a finished result when empty or being drained, so the
  // sequencer can go back to accepting while the previous transaction waits here.
  assign rsp_take = rsp_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the tagged index table: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import tidx_pkg::*;

  // Opcodes the block does not define; it must answer them with an all-zero failure.
  localparam logic [MODE_W-1:0] MODE_BAD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_BAD7 = 3'd7;

  // Cycles with no transaction on either channel before the run is called hung.
  // The slowest item is a full scan miss plus a random gap on each side;
  // the one long receiver hold-off below is PARK_CYCLES.
  localparam int PARK_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 108;
  localparam int N_PHASES    = 10;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  tidx_req_t         in_data;
  logic              out_valid;
  logic              out_ready;
  tidx_rsp_t         out_data;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  tagged_index_table_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the slot table, advanced once per accepted request
  // transaction, and of table_size, updated on each config write.
  // ---------------------------------------------------------------------------
  logic                slot_live [ENTRIES];
  logic [KEY_BITS-1:0] slot_key  [ENTRIES];
  logic [SIZE_W-1:0]   size_now;

  tidx_rsp_t rsp_due [$];   // responses owed by the block, oldest first
  int        n_bad;
  int        quiet_cycles;
  int        park_len;      // set once by the stimulus to hold the receiver off
  bit        calm;          // no idling on either side in the closing stretch
  int        gap_odds;      // sender gap chance 1 in gap_odds, 0 = never

  function automatic int live_size();
    return (size_now > ENTRIES) ? ENTRIES : int'(size_now);
  endfunction

  // Apply one request to the shadow table and return the response it must produce.
  function automatic tidx_rsp_t table_apply(input tidx_req_t r);
    tidx_rsp_t           rsp;
    int                  lim;
    int                  hit;
    logic [KEY_BITS-1:0] k;
    rsp = '0;
    lim = live_size();
    hit = -1;
    k   = r.global_key[KEY_BITS-1:0];
    case (r.mode)
      MODE_FIND_FREE, MODE_LOOKUP, MODE_FREE_KEY: begin
        // Lowest slot wins: free slot for find-free, live matching key otherwise.
        for (int i = 0; i < lim; i++) begin
          if (hit < 0) begin
            if (r.mode == MODE_FIND_FREE) begin
              if (!slot_live[i]) hit = i;
            end else if (slot_live[i] && slot_key[i] == k) begin
              hit = i;
            end
          end
        end
        if (hit >= 0) begin
          rsp.ok       = 1'b1;
          rsp.slot_out = hit[SLOT_W-1:0];
          if (r.mode == MODE_FREE_KEY) begin
            slot_live[hit] = 1'b0;
            slot_key[hit]  = '0;
          end
        end
      end
      MODE_SET_SLOT: begin
        if (int'(r.slot_number) < lim) begin
          slot_live[r.slot_number] = 1'b1;
          slot_key[r.slot_number]  = k;
          rsp.ok = 1'b1;
        end
      end
      MODE_FREE_SLOT: begin
        if (int'(r.slot_number) < lim) begin
          slot_live[r.slot_number] = 1'b0;
          slot_key[r.slot_number]  = '0;
          rsp.ok = 1'b1;
        end
      end
      MODE_READ_SLOT: begin
        // Inactive slots read back a zero key.
        if (int'(r.slot_number) < lim) begin
          rsp.ok      = 1'b1;
          rsp.key_out = slot_key[r.slot_number];
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Every call starts right after a rising edge; in_valid gets at
  // most one nonblocking update per edge, and stays high across back-to-back
  // transactions.
  // ---------------------------------------------------------------------------
  task automatic push_req(input tidx_req_t r, input bit known, input tidx_rsp_t known_rsp);
    tidx_rsp_t pred;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    // Accepted at this edge: advance the shadow table and queue the response.
    pred = table_apply(r);
    rsp_due.push_back(known ? known_rsp : pred);
  endtask

  // Write table_size only once the block has handed back everything it owes.
  task automatic set_table_size(input logic [SIZE_W-1:0] v);
    in_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    size_now = v;
    cfg_we   <= 1'b0;
  endtask

  // Random request, weighted so that sets and frees keep the table part full and
  // most lookups hit; keys come mostly from a small pool so that they repeat.
  function automatic tidx_req_t make_req();
    tidx_req_t         r;
    int                pick;
    int                lim;
    logic [GKEY_W-1:0] key_pool [6];
    key_pool = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h1234, 16'h8001, 16'h00FF};
    lim  = live_size();
    pick = $urandom_range(0, 99);
    if      (pick < 8)  r.mode = MODE_FIND_FREE;
    else if (pick < 28) r.mode = MODE_LOOKUP;
    else if (pick < 55) r.mode = MODE_SET_SLOT;
    else if (pick < 67) r.mode = MODE_FREE_SLOT;
    else if (pick < 80) r.mode = MODE_FREE_KEY;
    else if (pick < 95) r.mode = MODE_READ_SLOT;
    else                r.mode = ($urandom_range(0, 1) != 0) ? MODE_BAD6 : MODE_BAD7;
    if ($urandom_range(0, 3) == 0) r.global_key = GKEY_W'($urandom);
    else                           r.global_key = key_pool[$urandom_range(0, 5)];
    if (lim > 0 && $urandom_range(0, 4) != 0) r.slot_number = SLOT_W'($urandom_range(0, lim - 1));
    else                                      r.slot_number = SLOT_W'($urandom_range(0, 15));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stall bursts, stretches with no stalls, and one long
  // hold-off so the block backs up into its request port.
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int stall_odds;
    int odds_menu [3];
    odds_menu  = '{0, 3, 12};
    stall_odds = 0;
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (park_len > 0) begin
        out_ready <= 1'b0;
        repeat (park_len) @(posedge clk);
        park_len = 0;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
        if ($urandom_range(0, 39) == 0) stall_odds = odds_menu[$urandom_range(0, 2)];
      end
    end
  end

  // Compare every accepted response with the oldest one owed.
  tidx_rsp_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (rsp_due.size() == 0) begin
        n_bad++;
        $display("%0t: response with none owed: ok=%0b slot=%0d key=%h",
                 $time, out_data.ok, out_data.slot_out, out_data.key_out);
      end else begin
        want = rsp_due.pop_front();
        if (out_data.ok !== want.ok) begin
          n_bad++;
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_data.ok);
        end
        if (out_data.slot_out !== want.slot_out) begin
          n_bad++;
          $display("%0t: slot_out expected %0d actual %0d",
                   $time, want.slot_out, out_data.slot_out);
        end
        if (out_data.key_out !== want.key_out) begin
          n_bad++;
          $display("%0t: key_out expected %h actual %h", $time, want.key_out, out_data.key_out);
        end
      end
    end
  end

  // Hang detector: reset the count on any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. A row either writes table_size (value in the low key bits)
  // or sends a request; rows marked known carry a response read straight off the
  // spec, the rest are checked against the shadow table.
  // ---------------------------------------------------------------------------
  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [MODE_W-1:0] mode;
    logic [GKEY_W-1:0] key;
    logic [SLOT_W-1:0] slot;
    bit                known;
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [GKEY_W-1:0] key_out;
  } dir_row_t;

  dir_row_t dir_tab [26];

  initial begin : stim
    tidx_req_t         r;
    tidx_rsp_t         k_rsp;
    logic [SIZE_W-1:0] phase_sizes [N_PHASES];
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    n_bad     = 0;
    park_len  = 0;
    calm      = 1'b0;
    gap_odds  = 4;
    size_now  = SIZE_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_live[i] = 1'b0;
      slot_key[i]  = '0;
    end

    dir_tab = '{
      // fresh table: every key reads zero, nothing is live
      '{ROW_REQ, MODE_READ_SLOT, 16'h0000, 4'd0,  1'b1, 1'b1, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_FIND_FREE, 16'h0000, 4'd0,  1'b1, 1'b1, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_LOOKUP,    16'h0000, 4'd0,  1'b1, 1'b0, 4'd0,  16'h0000},
      // extreme keys into the extreme slots
      '{ROW_REQ, MODE_SET_SLOT,  16'hFFFF, 4'd0,  1'b1, 1'b1, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_SET_SLOT,  16'h0000, 4'd15, 1'b1, 1'b1, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_LOOKUP,    16'hFFFF, 4'd0,  1'b1, 1'b1, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_LOOKUP,    16'h0000, 4'd0,  1'b1, 1'b1, 4'd15, 16'h0000},
      '{ROW_REQ, MODE_FIND_FREE, 16'h0000, 4'd0,  1'b1, 1'b1, 4'd1,  16'h0000},
      '{ROW_REQ, MODE_READ_SLOT, 16'h0000, 4'd15, 1'b1, 1'b1, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_READ_SLOT, 16'h0000, 4'd0,  1'b1, 1'b1, 4'd0,  16'hFFFF},
      // undefined opcodes
      '{ROW_REQ, MODE_BAD6,      16'hFFFF, 4'd15, 1'b1, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_BAD7,      16'h0000, 4'd0,  1'b1, 1'b0, 4'd0,  16'h0000},
      // duplicate key: lowest slot is found and freed first
      '{ROW_REQ, MODE_SET_SLOT,  16'hA5A5, 4'd7,  1'b0, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_SET_SLOT,  16'hA5A5, 4'd3,  1'b0, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_LOOKUP,    16'hA5A5, 4'd0,  1'b0, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_FREE_KEY,  16'hA5A5, 4'd0,  1'b0, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_LOOKUP,    16'hA5A5, 4'd0,  1'b0, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_FREE_SLOT, 16'h0000, 4'd7,  1'b1, 1'b1, 4'd0,  16'h0000},
      // miss on free by key, and a freed slot reads back zero
      '{ROW_REQ, MODE_FREE_KEY,  16'hA5A5, 4'd0,  1'b1, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_READ_SLOT, 16'h0000, 4'd7,  1'b1, 1'b1, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_FREE_KEY,  16'hFFFF, 4'd0,  1'b1, 1'b1, 4'd0,  16'h0000},
      // one-slot table: full after one set, higher slots out of range
      '{ROW_CFG, MODE_FIND_FREE, 16'h0001, 4'd0,  1'b0, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_SET_SLOT,  16'h1234, 4'd0,  1'b1, 1'b1, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_FIND_FREE, 16'h0000, 4'd0,  1'b1, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_SET_SLOT,  16'h0001, 4'd1,  1'b1, 1'b0, 4'd0,  16'h0000},
      '{ROW_REQ, MODE_READ_SLOT, 16'h0000, 4'd15, 1'b1, 1'b0, 4'd0,  16'h0000}
    };

    // Sizes for the random phases: empty, saturated, the smallest, full and between.
    phase_sizes = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd16, 5'd8, 5'd2, 5'd15, 5'd5, 5'd16};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        set_table_size(dir_tab[i].key[SIZE_W-1:0]);
      end else begin
        r.mode         = dir_tab[i].mode;
        r.global_key   = dir_tab[i].key;
        r.slot_number  = dir_tab[i].slot;
        k_rsp.ok       = dir_tab[i].ok;
        k_rsp.slot_out = dir_tab[i].slot_out;
        k_rsp.key_out  = dir_tab[i].key_out;
        push_req(r, dir_tab[i].known, k_rsp);
      end
    end

    k_rsp = '0;
    for (int p = 0; p < N_PHASES; p++) begin
      set_table_size(phase_sizes[p]);
      // Hold the receiver off early in one full-size phase while requests keep coming.
      if (p == 4) park_len = PARK_CYCLES;
      // Drop all idling for the closing phase.
      if (p == N_PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        push_req(make_req(), 1'b0, k_rsp);
      end
    end

    in_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    // Give a late or duplicate response time to show up.
    repeat (40) @(posedge clk);
    n_bad += rsp_due.size();

    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
